/* rtl/srfc_pkg.sv */
package srfc_pkg;

    // sizes
    localparam int FRAME_DEPTH = 64;
    localparam int MAX_DATA    = 16;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int MIN_FRAME   = 7;
    localparam int DATA_OFS    = 5;
    localparam int HDR_BYTES   = 5;
    localparam int LEN_BYTE    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // codes
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_CLOSE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_RESP    = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_SLAVE_ADDR = 3'd0,
        REG_EXP_CMD    = 3'd1,
        REG_MAX_LEN    = 3'd2,
        REG_START      = 3'd3,
        REG_STOP       = 3'd4
    } t_reg_idx;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_bk_state;

    // payload words
    typedef struct packed {
        t_cmd              command;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic [LEN_W-1:0]  data_length;
        logic              last_result;
    } t_result;

    // configuration set
    typedef struct packed {
        logic [BYTE_W-1:0] slave_address;
        logic [BYTE_W-1:0] expected_command;
        logic [LEN_W-1:0]  max_data_len;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] stop_byte;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        slave_address:    8'h00,
        expected_command: 8'h00,
        max_data_len:     5'd16,
        start_byte:       8'h7E,
        stop_byte:        8'h7E
    };

    // checked frame handed from front to back
    typedef struct packed {
        t_status          status;
        logic [LEN_W-1:0] len;
    } t_job;

    // frame store read request from back to front
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* rtl/srfc_front.sv */
module srfc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  srfc_pkg::t_in_item          i_item,
    input  srfc_pkg::t_cfg              i_cfg,
    input  srfc_pkg::t_rd_req           i_rd_req,
    output logic [srfc_pkg::BYTE_W-1:0] o_rd_data,
    output logic                        o_push,
    output srfc_pkg::t_job              o_job
);

    logic [srfc_pkg::BYTE_W-1:0] r_mem [srfc_pkg::FRAME_DEPTH];
    logic [srfc_pkg::BYTE_W-1:0] r_rd_data;
    logic [srfc_pkg::ADDR_W-1:0] r_cnt;
    logic [srfc_pkg::ADDR_W-1:0] n_cnt;
    logic [srfc_pkg::BYTE_W-1:0] r_hdr [srfc_pkg::HDR_BYTES];
    logic [srfc_pkg::BYTE_W-1:0] r_sum;
    logic [srfc_pkg::BYTE_W-1:0] r_last1;
    logic [srfc_pkg::BYTE_W-1:0] r_last2;

    logic                        is_store;
    logic                        is_close;
    logic [srfc_pkg::BYTE_W-1:0] sum_body;
    logic [7:0]                  n_bytes;
    logic [7:0]                  avail;
    logic [7:0]                  len_clip;

    assign is_store = i_accept && (i_item.command == srfc_pkg::CMD_STORE);
    assign is_close = i_accept && (i_item.command == srfc_pkg::CMD_CLOSE);

    // frame store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (is_store) begin
            r_mem[r_cnt] <= i_item.rx_byte;
        end
        if (i_rd_req.en) begin
            r_rd_data <= r_mem[i_rd_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

    // running header capture, body sum and last two bytes
    always_ff @(posedge i_clk) begin
        if (is_store) begin
            r_last1 <= i_item.rx_byte;
            r_last2 <= r_last1;
            if (r_cnt == '0) begin
                r_sum <= '0;
            end else begin
                r_sum <= r_sum + i_item.rx_byte;
            end
            for (int h = 0; h < srfc_pkg::HDR_BYTES; h++) begin
                if (r_cnt == srfc_pkg::ADDR_W'(h)) begin
                    r_hdr[h] <= i_item.rx_byte;
                end
            end
        end
    end

    // write index, wraps at store depth, cleared by close
    always_comb begin
        n_cnt = r_cnt;
        if (is_close) begin
            n_cnt = '0;
        end else if (is_store) begin
            if (r_cnt == srfc_pkg::ADDR_W'(srfc_pkg::FRAME_DEPTH - 1)) begin
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + srfc_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // frame check on close: sum of bytes 1..n-3 is total less the last two
    assign sum_body = r_sum - r_last1 - r_last2;
    assign n_bytes  = 8'(r_cnt);
    assign avail    = n_bytes - 8'(srfc_pkg::MIN_FRAME);

    always_comb begin
        len_clip = r_hdr[srfc_pkg::LEN_BYTE];
        if (len_clip > {3'b000, i_cfg.max_data_len}) begin
            len_clip = {3'b000, i_cfg.max_data_len};
        end
        if (len_clip > 8'(srfc_pkg::MAX_DATA)) begin
            len_clip = 8'(srfc_pkg::MAX_DATA);
        end
        if (len_clip > avail) begin
            len_clip = avail;
        end
    end

    always_comb begin
        o_job.len = srfc_pkg::LEN_W'(len_clip);
        priority if (n_bytes < 8'(srfc_pkg::MIN_FRAME)
                     || r_hdr[0] != i_cfg.start_byte
                     || r_last1 != i_cfg.stop_byte) begin
            o_job.status = srfc_pkg::ST_TIMEOUT;
        end else if (r_last2 != ~sum_body) begin
            o_job.status = srfc_pkg::ST_CRC;
        end else if (r_hdr[1] != i_cfg.slave_address
                     || r_hdr[2] != i_cfg.expected_command
                     || r_hdr[3] != 8'h00) begin
            o_job.status = srfc_pkg::ST_RESP;
        end else begin
            o_job.status = srfc_pkg::ST_OK;
        end
    end

    assign o_push = is_close;

endmodule

/* rtl/srfc_queue.sv */
module srfc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srfc_pkg::t_job    i_job,
    input  logic              i_pop,
    output srfc_pkg::t_job    o_head,
    output srfc_pkg::t_q_stat o_stat
);

    srfc_pkg::t_job               r_q [srfc_pkg::QUEUE_DEPTH];
    logic [srfc_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [srfc_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [srfc_pkg::Q_CNT_W-1:0] r_count;

    function automatic logic [srfc_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [srfc_pkg::Q_PTR_W-1:0] ptr
    );
        if (ptr == srfc_pkg::Q_PTR_W'(srfc_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + srfc_pkg::Q_PTR_W'(1);
    endfunction

    // job entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + srfc_pkg::Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - srfc_pkg::Q_CNT_W'(1);
            end
        end
    end

    assign o_head     = r_q[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == srfc_pkg::Q_CNT_W'(srfc_pkg::QUEUE_DEPTH));

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("job popped from empty queue");

    a_level_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_stat.empty)
        else $error("queue empty after push");
`endif

endmodule

/* rtl/srfc_back.sv */
module srfc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srfc_pkg::t_job              i_head,
    input  srfc_pkg::t_q_stat           i_q_stat,
    input  logic [srfc_pkg::BYTE_W-1:0] i_rd_data,
    output logic                        o_pop,
    output srfc_pkg::t_rd_req           o_rd_req,
    output logic                        o_active,
    output logic                        o_res_valid,
    output srfc_pkg::t_result           o_result
);

    srfc_pkg::t_bk_state        r_state;
    srfc_pkg::t_bk_state        n_state;
    logic [srfc_pkg::LEN_W-1:0] r_idx;
    logic [srfc_pkg::LEN_W-1:0] r_len;
    logic                       r_pend;
    logic                       r_pend_last;
    logic                       r_out_valid;
    srfc_pkg::t_result          r_out;

    logic                       single;
    logic                       start_run;
    logic                       is_last;

    assign is_last = ((r_idx + srfc_pkg::LEN_W'(1)) == r_len);

    // pop a job, then walk the data bytes one read per cycle
    always_comb begin
        n_state       = r_state;
        o_pop         = 1'b0;
        single        = 1'b0;
        start_run     = 1'b0;
        o_rd_req.en   = 1'b0;
        o_rd_req.addr = '0;
        unique case (r_state)
            srfc_pkg::BK_IDLE: begin
                if (!i_q_stat.empty && !r_pend) begin
                    o_pop = 1'b1;
                    if (i_head.status == srfc_pkg::ST_OK && i_head.len != '0) begin
                        start_run = 1'b1;
                        n_state   = srfc_pkg::BK_RUN;
                    end else begin
                        single = 1'b1;
                    end
                end
            end
            srfc_pkg::BK_RUN: begin
                o_rd_req.en   = 1'b1;
                o_rd_req.addr = srfc_pkg::ADDR_W'(r_idx + srfc_pkg::LEN_W'(srfc_pkg::DATA_OFS));
                if (is_last) begin
                    n_state = srfc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = srfc_pkg::BK_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srfc_pkg::BK_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= (r_state == srfc_pkg::BK_RUN);
            r_out_valid <= r_pend || single;
        end
    end

    // walk index and result word
    always_ff @(posedge i_clk) begin
        if (start_run) begin
            r_len <= i_head.len;
            r_idx <= '0;
        end else if (r_state == srfc_pkg::BK_RUN) begin
            r_idx <= r_idx + srfc_pkg::LEN_W'(1);
        end
        r_pend_last <= is_last;
        if (r_pend) begin
            r_out.status      <= srfc_pkg::ST_OK;
            r_out.data_byte   <= i_rd_data;
            r_out.data_valid  <= 1'b1;
            r_out.data_length <= r_len;
            r_out.last_result <= r_pend_last;
        end else if (single) begin
            r_out.status      <= i_head.status;
            r_out.data_byte   <= '0;
            r_out.data_valid  <= 1'b0;
            r_out.data_length <= '0;
            r_out.last_result <= 1'b1;
        end
    end

    assign o_active    = (r_state != srfc_pkg::BK_IDLE) || r_pend;
    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef NO_ASSERTIONS
    a_run_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srfc_pkg::BK_RUN) |-> (r_len != '0 && r_idx < r_len))
        else $error("data walk outside frame length");

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_result) |=> (r_out_valid && r_out.data_valid))
        else $error("gap inside data burst");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == srfc_pkg::BK_IDLE && !r_pend))
        else $error("job taken while previous one still running");
`endif

endmodule

/* rtl/shdlc_response_frame_checker_top.sv */
// Channel   Handshake                    Word
// input     start, accepted when !busy   i_item   (command, rx_byte)
// result    o_res_valid, one cycle       o_result (status .. last_result)
// config    APB write, pready always 1   pwdata at byte address 4*index
//
// A store word leaves busy low, and bytes may arrive every cycle.
// A close word raises busy; an error or empty-data result passes the queue and
// the output register, while a data burst passes queue pop, store read and
// output register, then gives one data result per cycle (up to 16).
// busy drops in the cycle the last result is shown.
// Synchronous active-low reset; no clearing pass. Results cannot be held off.
module shdlc_response_frame_checker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  srfc_pkg::t_in_item            i_item,
    output logic                          o_res_valid,
    output srfc_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [srfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [srfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    srfc_pkg::t_cfg              r_cfg;
    srfc_pkg::t_reg_idx          reg_idx;
    logic                        cfg_wr;
    logic                        accept;
    logic                        push;
    logic                        pop;
    logic                        bk_active;
    srfc_pkg::t_job              job;
    srfc_pkg::t_job              head;
    srfc_pkg::t_q_stat           q_stat;
    srfc_pkg::t_rd_req           rd_req;
    logic [srfc_pkg::BYTE_W-1:0] rd_data;

    // register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = srfc_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= srfc_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                srfc_pkg::REG_SLAVE_ADDR: r_cfg.slave_address    <= pwdata[7:0];
                srfc_pkg::REG_EXP_CMD:    r_cfg.expected_command <= pwdata[7:0];
                srfc_pkg::REG_MAX_LEN:    r_cfg.max_data_len     <= pwdata[4:0];
                srfc_pkg::REG_START:      r_cfg.start_byte       <= pwdata[7:0];
                srfc_pkg::REG_STOP:       r_cfg.stop_byte        <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            srfc_pkg::REG_SLAVE_ADDR: prdata = {24'h0, r_cfg.slave_address};
            srfc_pkg::REG_EXP_CMD:    prdata = {24'h0, r_cfg.expected_command};
            srfc_pkg::REG_MAX_LEN:    prdata = {27'h0, r_cfg.max_data_len};
            srfc_pkg::REG_START:      prdata = {24'h0, r_cfg.start_byte};
            srfc_pkg::REG_STOP:       prdata = {24'h0, r_cfg.stop_byte};
            default:                  prdata = '0;
        endcase
    end

    // busy while a close is queued or being walked
    assign busy   = !q_stat.empty || bk_active;
    assign accept = start && !busy;

    srfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_rd_req  (rd_req),
        .o_rd_data (rd_data),
        .o_push    (push),
        .o_job     (job)
    );

    srfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    srfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .i_rd_data   (rd_data),
        .o_pop       (pop),
        .o_rd_req    (rd_req),
        .o_active    (bk_active),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule
